[rtl/core/ocd_pkg.sv]
`timescale 1ns / 1ps

package ocd_pkg;

    localparam int ADDR_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int INSTR_ADDR_W = 16;

    localparam logic [1:0] LEN_1 = 2'd1;
    localparam logic [1:0] LEN_2 = 2'd2;
    localparam logic [1:0] LEN_3 = 2'd3;

    typedef enum logic [5:0] {
        MN_UNK, MN_ADC, MN_AND, MN_ASL, MN_BCC, MN_BCS, MN_BEQ, MN_BIT, MN_BMI,
        MN_BNE, MN_BPL, MN_BRK, MN_BVC, MN_BVS, MN_CLC, MN_CLD, MN_CLI, MN_CLV,
        MN_CMP, MN_CPX, MN_CPY, MN_DEC, MN_DEX, MN_DEY, MN_EOR, MN_INC, MN_INX,
        MN_INY, MN_JMP, MN_JSR, MN_LDA, MN_LDX, MN_LDY, MN_LSR, MN_NOP, MN_ORA,
        MN_PHA, MN_PHP, MN_PLA, MN_PLP, MN_ROL, MN_ROR, MN_RTI, MN_RTS, MN_SBC,
        MN_SEC, MN_SED, MN_SEI, MN_STA, MN_STX, MN_STY, MN_TAX, MN_TAY, MN_TSX,
        MN_TXA, MN_TXS, MN_TYA
    } t_mnem;

    typedef enum logic [3:0] {
        MD_UNK, MD_IMP, MD_ACC, MD_IMM, MD_ZP, MD_ZPX, MD_ZPY, MD_INX,
        MD_INY, MD_REL, MD_ABS, MD_ABX, MD_ABY, MD_IND
    } t_mode;

    typedef struct packed {
        t_mnem mn;
        t_mode md;
    } t_op_info;

    typedef struct packed {
        logic [INSTR_ADDR_W-1:0] addr;
        logic [7:0]              opcode;
        logic [7:0]              op_lo;
        logic [7:0]              op_hi;
        logic                    trunc;
        logic                    fin;
    } t_instr_rec;

    typedef struct packed {
        logic       push;
        t_instr_rec rec;
    } t_q_wr;

    function automatic t_op_info op_info(input logic [7:0] op);
        t_op_info r;
        r = '{MN_UNK, MD_UNK};
        case (op)
            8'h69: r = '{MN_ADC, MD_IMM};  8'h65: r = '{MN_ADC, MD_ZP};
            8'h75: r = '{MN_ADC, MD_ZPX};  8'h6D: r = '{MN_ADC, MD_ABS};
            8'h7D: r = '{MN_ADC, MD_ABX};  8'h79: r = '{MN_ADC, MD_ABY};
            8'h61: r = '{MN_ADC, MD_INX};  8'h71: r = '{MN_ADC, MD_INY};
            8'h29: r = '{MN_AND, MD_IMM};  8'h25: r = '{MN_AND, MD_ZP};
            8'h35: r = '{MN_AND, MD_ZPX};  8'h2D: r = '{MN_AND, MD_ABS};
            8'h3D: r = '{MN_AND, MD_ABX};  8'h39: r = '{MN_AND, MD_ABY};
            8'h21: r = '{MN_AND, MD_INX};  8'h31: r = '{MN_AND, MD_INY};
            8'hC9: r = '{MN_CMP, MD_IMM};  8'hC5: r = '{MN_CMP, MD_ZP};
            8'hD5: r = '{MN_CMP, MD_ZPX};  8'hCD: r = '{MN_CMP, MD_ABS};
            8'hDD: r = '{MN_CMP, MD_ABX};  8'hD9: r = '{MN_CMP, MD_ABY};
            8'hC1: r = '{MN_CMP, MD_INX};  8'hD1: r = '{MN_CMP, MD_INY};
            8'h49: r = '{MN_EOR, MD_IMM};  8'h45: r = '{MN_EOR, MD_ZP};
            8'h55: r = '{MN_EOR, MD_ZPX};  8'h4D: r = '{MN_EOR, MD_ABS};
            8'h5D: r = '{MN_EOR, MD_ABX};  8'h59: r = '{MN_EOR, MD_ABY};
            8'h41: r = '{MN_EOR, MD_INX};  8'h51: r = '{MN_EOR, MD_INY};
            8'hA9: r = '{MN_LDA, MD_IMM};  8'hA5: r = '{MN_LDA, MD_ZP};
            8'hB5: r = '{MN_LDA, MD_ZPX};  8'hAD: r = '{MN_LDA, MD_ABS};
            8'hBD: r = '{MN_LDA, MD_ABX};  8'hB9: r = '{MN_LDA, MD_ABY};
            8'hA1: r = '{MN_LDA, MD_INX};  8'hB1: r = '{MN_LDA, MD_INY};
            8'h09: r = '{MN_ORA, MD_IMM};  8'h05: r = '{MN_ORA, MD_ZP};
            8'h15: r = '{MN_ORA, MD_ZPX};  8'h0D: r = '{MN_ORA, MD_ABS};
            8'h1D: r = '{MN_ORA, MD_ABX};  8'h19: r = '{MN_ORA, MD_ABY};
            8'h01: r = '{MN_ORA, MD_INX};  8'h11: r = '{MN_ORA, MD_INY};
            8'hE9: r = '{MN_SBC, MD_IMM};  8'hE5: r = '{MN_SBC, MD_ZP};
            8'hF5: r = '{MN_SBC, MD_ZPX};  8'hED: r = '{MN_SBC, MD_ABS};
            8'hFD: r = '{MN_SBC, MD_ABX};  8'hF9: r = '{MN_SBC, MD_ABY};
            8'hE1: r = '{MN_SBC, MD_INX};  8'hF1: r = '{MN_SBC, MD_INY};
            8'h85: r = '{MN_STA, MD_ZP};   8'h95: r = '{MN_STA, MD_ZPX};
            8'h8D: r = '{MN_STA, MD_ABS};  8'h9D: r = '{MN_STA, MD_ABX};
            8'h99: r = '{MN_STA, MD_ABY};  8'h81: r = '{MN_STA, MD_INX};
            8'h91: r = '{MN_STA, MD_INY};
            8'h0A: r = '{MN_ASL, MD_ACC};  8'h06: r = '{MN_ASL, MD_ZP};
            8'h16: r = '{MN_ASL, MD_ZPX};  8'h0E: r = '{MN_ASL, MD_ABS};
            8'h1E: r = '{MN_ASL, MD_ABX};
            8'h4A: r = '{MN_LSR, MD_ACC};  8'h46: r = '{MN_LSR, MD_ZP};
            8'h56: r = '{MN_LSR, MD_ZPX};  8'h4E: r = '{MN_LSR, MD_ABS};
            8'h5E: r = '{MN_LSR, MD_ABX};
            8'h2A: r = '{MN_ROL, MD_ACC};  8'h26: r = '{MN_ROL, MD_ZP};
            8'h36: r = '{MN_ROL, MD_ZPX};  8'h2E: r = '{MN_ROL, MD_ABS};
            8'h3E: r = '{MN_ROL, MD_ABX};
            8'h6A: r = '{MN_ROR, MD_ACC};  8'h66: r = '{MN_ROR, MD_ZP};
            8'h76: r = '{MN_ROR, MD_ZPX};  8'h6E: r = '{MN_ROR, MD_ABS};
            8'h7E: r = '{MN_ROR, MD_ABX};
            8'h24: r = '{MN_BIT, MD_ZP};   8'h2C: r = '{MN_BIT, MD_ABS};
            8'h10: r = '{MN_BPL, MD_REL};  8'h30: r = '{MN_BMI, MD_REL};
            8'h50: r = '{MN_BVC, MD_REL};  8'h70: r = '{MN_BVS, MD_REL};
            8'h90: r = '{MN_BCC, MD_REL};  8'hB0: r = '{MN_BCS, MD_REL};
            8'hD0: r = '{MN_BNE, MD_REL};  8'hF0: r = '{MN_BEQ, MD_REL};
            8'hE0: r = '{MN_CPX, MD_IMM};  8'hE4: r = '{MN_CPX, MD_ZP};
            8'hEC: r = '{MN_CPX, MD_ABS};
            8'hC0: r = '{MN_CPY, MD_IMM};  8'hC4: r = '{MN_CPY, MD_ZP};
            8'hCC: r = '{MN_CPY, MD_ABS};
            8'hC6: r = '{MN_DEC, MD_ZP};   8'hD6: r = '{MN_DEC, MD_ZPX};
            8'hCE: r = '{MN_DEC, MD_ABS};  8'hDE: r = '{MN_DEC, MD_ABX};
            8'hE6: r = '{MN_INC, MD_ZP};   8'hF6: r = '{MN_INC, MD_ZPX};
            8'hEE: r = '{MN_INC, MD_ABS};  8'hFE: r = '{MN_INC, MD_ABX};
            8'h4C: r = '{MN_JMP, MD_ABS};  8'h6C: r = '{MN_JMP, MD_IND};
            8'h20: r = '{MN_JSR, MD_ABS};
            8'hA2: r = '{MN_LDX, MD_IMM};  8'hA6: r = '{MN_LDX, MD_ZP};
            8'hB6: r = '{MN_LDX, MD_ZPY};  8'hAE: r = '{MN_LDX, MD_ABS};
            8'hBE: r = '{MN_LDX, MD_ABY};
            8'hA0: r = '{MN_LDY, MD_IMM};  8'hA4: r = '{MN_LDY, MD_ZP};
            8'hB4: r = '{MN_LDY, MD_ZPX};  8'hAC: r = '{MN_LDY, MD_ABS};
            8'hBC: r = '{MN_LDY, MD_ABX};
            8'h86: r = '{MN_STX, MD_ZP};   8'h96: r = '{MN_STX, MD_ZPY};
            8'h8E: r = '{MN_STX, MD_ABS};
            8'h84: r = '{MN_STY, MD_ZP};   8'h94: r = '{MN_STY, MD_ZPX};
            8'h8C: r = '{MN_STY, MD_ABS};
            8'h00: r = '{MN_BRK, MD_IMP};  8'h18: r = '{MN_CLC, MD_IMP};
            8'hD8: r = '{MN_CLD, MD_IMP};  8'h58: r = '{MN_CLI, MD_IMP};
            8'hB8: r = '{MN_CLV, MD_IMP};  8'hCA: r = '{MN_DEX, MD_IMP};
            8'h88: r = '{MN_DEY, MD_IMP};  8'hE8: r = '{MN_INX, MD_IMP};
            8'hC8: r = '{MN_INY, MD_IMP};  8'hEA: r = '{MN_NOP, MD_IMP};
            8'h48: r = '{MN_PHA, MD_IMP};  8'h08: r = '{MN_PHP, MD_IMP};
            8'h68: r = '{MN_PLA, MD_IMP};  8'h28: r = '{MN_PLP, MD_IMP};
            8'h40: r = '{MN_RTI, MD_IMP};  8'h60: r = '{MN_RTS, MD_IMP};
            8'h38: r = '{MN_SEC, MD_IMP};  8'hF8: r = '{MN_SED, MD_IMP};
            8'h78: r = '{MN_SEI, MD_IMP};  8'hAA: r = '{MN_TAX, MD_IMP};
            8'hA8: r = '{MN_TAY, MD_IMP};  8'hBA: r = '{MN_TSX, MD_IMP};
            8'h8A: r = '{MN_TXA, MD_IMP};  8'h9A: r = '{MN_TXS, MD_IMP};
            8'h98: r = '{MN_TYA, MD_IMP};
            default: r = '{MN_UNK, MD_UNK};
        endcase
        return r;
    endfunction

    function automatic logic [1:0] mode_len(input t_mode md);
        logic [1:0] len;
        if (md inside {MD_UNK, MD_IMP, MD_ACC}) begin
            len = LEN_1;
        end else if (md inside {[MD_IMM:MD_REL]}) begin
            len = LEN_2;
        end else begin
            len = LEN_3;
        end
        return len;
    endfunction

endpackage

[rtl/core/ocd_front.sv]
`timescale 1ns / 1ps

module ocd_front
    import ocd_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_code_byte,
    input  logic        i_end_of_stream,
    input  logic        i_q_full,
    output t_q_wr       o_q_wr
);

    typedef enum logic [1:0] {
        POS_OPCODE,
        POS_OP1,
        POS_OP2
    } t_pos;

    t_pos                  r_pos, n_pos;
    logic                  r_at_start, n_at_start;
    logic [15:0]           r_base;
    logic [ADDR_BITS-1:0]  r_next_addr, n_next_addr;
    logic [15:0]           r_start, n_start;
    logic [7:0]            r_opcode, n_opcode;
    logic [7:0]            r_operand, n_operand;
    logic [1:0]            r_len, n_len;

    logic                  accept;
    logic [ADDR_BITS-1:0]  cur_addr;
    logic [1:0]            byte_len;
    t_q_wr                 q_wr;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign cur_addr   = r_at_start ? ADDR_BITS'(r_base) : r_next_addr;
    assign byte_len   = mode_len(op_info(i_code_byte).md);
    assign o_q_wr     = q_wr;

    always_comb begin
        n_pos       = r_pos;
        n_at_start  = r_at_start;
        n_next_addr = r_next_addr;
        n_start     = r_start;
        n_opcode    = r_opcode;
        n_operand   = r_operand;
        n_len       = r_len;
        q_wr        = '0;
        q_wr.rec.fin = i_end_of_stream;
        if (accept) begin
            case (r_pos)
                POS_OPCODE: begin
                    n_start          = cur_addr[15:0];
                    n_opcode         = i_code_byte;
                    n_operand        = '0;
                    n_len            = byte_len;
                    q_wr.rec.addr    = cur_addr[15:0];
                    q_wr.rec.opcode  = i_code_byte;
                    if (byte_len == LEN_1) begin
                        q_wr.push = 1'b1;
                    end else if (i_end_of_stream) begin
                        q_wr.push       = 1'b1;
                        q_wr.rec.trunc  = 1'b1;
                    end else begin
                        n_pos = POS_OP1;
                    end
                end
                POS_OP1: begin
                    q_wr.rec.addr   = r_start;
                    q_wr.rec.opcode = r_opcode;
                    q_wr.rec.op_lo  = i_code_byte;
                    if (r_len == LEN_2) begin
                        q_wr.push = 1'b1;
                        n_pos     = POS_OPCODE;
                    end else if (i_end_of_stream) begin
                        q_wr.push      = 1'b1;
                        q_wr.rec.trunc = 1'b1;
                        n_pos          = POS_OPCODE;
                    end else begin
                        n_operand = i_code_byte;
                        n_pos     = POS_OP2;
                    end
                end
                POS_OP2: begin
                    q_wr.push       = 1'b1;
                    q_wr.rec.addr   = r_start;
                    q_wr.rec.opcode = r_opcode;
                    q_wr.rec.op_lo  = r_operand;
                    q_wr.rec.op_hi  = i_code_byte;
                    n_pos           = POS_OPCODE;
                end
                default: begin
                    n_pos = POS_OPCODE;
                end
            endcase
            if (i_end_of_stream) begin
                n_pos       = POS_OPCODE;
                n_at_start  = 1'b1;
                n_next_addr = ADDR_BITS'(r_base);
            end else begin
                n_at_start  = 1'b0;
                n_next_addr = cur_addr + ADDR_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_OPCODE;
            r_at_start  <= 1'b1;
            r_base      <= '0;
            r_next_addr <= '0;
            r_start     <= '0;
            r_opcode    <= '0;
            r_operand   <= '0;
            r_len       <= LEN_1;
        end else begin
            r_pos       <= n_pos;
            r_at_start  <= n_at_start;
            r_next_addr <= n_next_addr;
            r_start     <= n_start;
            r_opcode    <= n_opcode;
            r_operand   <= n_operand;
            r_len       <= n_len;
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
        end
    end

endmodule

[rtl/core/ocd_fifo.sv]
`timescale 1ns / 1ps

module ocd_fifo
    import ocd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_wr      i_q_wr,
    input  logic       i_pop,
    output logic       o_full,
    output logic       o_nempty,
    output t_instr_rec o_head
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

    t_instr_rec        r_mem [DEPTH];
    logic [IDX_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push, do_pop;

    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign o_nempty = (r_count != '0);
    assign o_head   = r_mem[r_rd_ptr];
    assign do_push  = i_q_wr.push && !o_full;
    assign do_pop   = i_pop && o_nempty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_q_wr.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + IDX_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + IDX_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/core/ocd_back.sv]
`timescale 1ns / 1ps

module ocd_back
    import ocd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_nempty,
    input  t_instr_rec  i_head,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_instr_address,
    output logic [7:0]  o_opcode_value,
    output logic [5:0]  o_mnemonic_code,
    output logic [3:0]  o_address_mode,
    output logic [1:0]  o_instr_length,
    output logic [7:0]  o_operand_low,
    output logic [7:0]  o_operand_high,
    output logic        o_truncated,
    output logic        o_final_result
);

    logic        r_valid;
    logic [15:0] r_addr;
    logic [7:0]  r_opcode;
    t_op_info    r_info;
    logic [1:0]  r_len;
    logic [7:0]  r_lo, r_hi;
    logic        r_trunc, r_fin;
    t_op_info    head_info;

    assign head_info = op_info(i_head.opcode);
    assign o_pop     = i_q_nempty && (!r_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // result register, loaded on each queue transfer
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_addr   <= i_head.addr;
            r_opcode <= i_head.opcode;
            r_info   <= head_info;
            r_len    <= mode_len(head_info.md);
            r_lo     <= i_head.op_lo;
            r_hi     <= i_head.op_hi;
            r_trunc  <= i_head.trunc;
            r_fin    <= i_head.fin;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_instr_address = r_addr;
    assign o_opcode_value  = r_opcode;
    assign o_mnemonic_code = r_info.mn;
    assign o_address_mode  = r_info.md;
    assign o_instr_length  = r_len;
    assign o_operand_low   = r_lo;
    assign o_operand_high  = r_hi;
    assign o_truncated     = r_trunc;
    assign o_final_result  = r_fin;

endmodule

[rtl/core/opcode_stream_instruction_decoder_core.sv]
// path: the last byte's record is written into the queue, then into the result register
// throughput: one code byte per cycle when not stalled, one instruction result per cycle
// the two-entry queue between byte assembly and result register sets the stall
// reset: synchronous active low; clears position, stream start, base and queue
`timescale 1ns / 1ps

module opcode_stream_instruction_decoder_core
    import ocd_pkg::*;
#(
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_code_byte,
    input  logic        i_end_of_stream,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_instr_address,
    output logic [7:0]  o_opcode_value,
    output logic [5:0]  o_mnemonic_code,
    output logic [3:0]  o_address_mode,
    output logic [1:0]  o_instr_length,
    output logic [7:0]  o_operand_low,
    output logic [7:0]  o_operand_high,
    output logic        o_truncated,
    output logic        o_final_result
);

    t_q_wr      q_wr;
    logic       q_full, q_nempty, q_pop;
    t_instr_rec q_head;

    ocd_front #(
        .ADDR_BITS(ADDR_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_code_byte    (i_code_byte),
        .i_end_of_stream(i_end_of_stream),
        .i_q_full       (q_full),
        .o_q_wr         (q_wr)
    );

    ocd_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_wr  (q_wr),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_nempty(q_nempty),
        .o_head  (q_head)
    );

    ocd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_nempty     (q_nempty),
        .i_head         (q_head),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_instr_address(o_instr_address),
        .o_opcode_value (o_opcode_value),
        .o_mnemonic_code(o_mnemonic_code),
        .o_address_mode (o_address_mode),
        .o_instr_length (o_instr_length),
        .o_operand_low  (o_operand_low),
        .o_operand_high (o_operand_high),
        .o_truncated    (o_truncated),
        .o_final_result (o_final_result)
    );

endmodule

[rtl/core/ocd_checker.sv]
`timescale 1ns / 1ps

module ocd_checker
    import ocd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_instr_address,
    input logic [7:0]  o_opcode_value,
    input logic [5:0]  o_mnemonic_code,
    input logic [3:0]  o_address_mode,
    input logic [1:0]  o_instr_length,
    input logic [7:0]  o_operand_low,
    input logic [7:0]  o_operand_high,
    input logic        o_truncated,
    input logic        o_final_result
);

    // stalled transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_instr_address)
            && $stable(o_opcode_value) && $stable(o_operand_low)
            && $stable(o_operand_high) && $stable(o_final_result))
        else $error("stalled result changed");

    a_trunc_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_truncated |-> o_final_result && o_instr_length != LEN_1)
        else $error("truncated result not final or length one");

    a_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mnemonic_code == MN_UNK |-> o_address_mode == MD_UNK
            && o_instr_length == LEN_1 && o_operand_low == 8'h00
            && o_operand_high == 8'h00)
        else $error("unknown opcode with operands");

    a_short_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_instr_length != LEN_3 |-> o_operand_high == 8'h00)
        else $error("high operand on short instruction");

endmodule

bind opcode_stream_instruction_decoder_core ocd_checker u_ocd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_instr_address(o_instr_address),
    .o_opcode_value (o_opcode_value),
    .o_mnemonic_code(o_mnemonic_code),
    .o_address_mode (o_address_mode),
    .o_instr_length (o_instr_length),
    .o_operand_low  (o_operand_low),
    .o_operand_high (o_operand_high),
    .o_truncated    (o_truncated),
    .o_final_result (o_final_result)
);
